// ===== src/sst_pkg.sv =====
// Package for the sparse triple transpose block.
// Holds the controller/datapath command and status types; no dependencies.
`default_nettype none
package sst_pkg;

  typedef enum logic [5:0] {
    ST_LOAD  = 6'b000001,
    ST_CLEAR = 6'b000010,
    ST_COUNT = 6'b000100,
    ST_PREF  = 6'b001000,
    ST_SCAT  = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_e;

  localparam logic CFG_ROW_COUNT = 1'b0;
  localparam logic CFG_COL_COUNT = 1'b1;

  typedef struct packed {
    logic load;
    logic clear;
    logic count;
    logic pref;
    logic scat;
    logic emit;
    logic emit_step;
    logic run_done;
  } sst_cmd_t;

  typedef struct packed {
    logic total_zero;
    logic sweep_done;
    logic item_done;
    logic emit_last;
  } sst_status_t;

endpackage
`default_nettype wire

// ===== src/sst_if.sv =====
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
`default_nettype none
interface sst_if #(parameter int W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/sst_ctrl.sv =====
// Controller state machine of the sparse triple transpose block.
// Depends on sst_pkg.
`default_nettype none
module sst_ctrl
  import sst_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_fire_i,
  input  wire logic        in_last_i,
  input  wire logic        out_free_i,
  input  sst_status_t      status_i,
  output sst_cmd_t         cmd_o,
  output logic             in_ready_o
);
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_LOAD;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_fire_i;
        if (in_fire_i && in_last_i) state_d = ST_CLEAR;
      end
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.sweep_done) state_d = ST_COUNT;
      end
      ST_COUNT: begin
        cmd_o.count = 1'b1;
        if (status_i.total_zero) begin
          cmd_o.run_done = 1'b1;
          state_d = ST_LOAD;
        end else if (status_i.item_done) state_d = ST_PREF;
      end
      ST_PREF: begin
        cmd_o.pref = 1'b1;
        if (status_i.sweep_done) state_d = ST_SCAT;
      end
      ST_SCAT: begin
        cmd_o.scat = 1'b1;
        if (status_i.item_done) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        cmd_o.emit = 1'b1;
        if (out_free_i) begin
          cmd_o.emit_step = 1'b1;
          if (status_i.emit_last) begin
            cmd_o.run_done = 1'b1;
            state_d = ST_LOAD;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == ST_LOAD) else $error("ready outside load");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit_step |-> cmd_o.emit) else $error("emit step outside emit");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.run_done |=> state_q == ST_LOAD) else $error("run end not back to load");
endmodule
`default_nettype wire

// ===== src/sst_dpath.sv =====
// Datapath: entry store, column tally, start slots, transposed store, output register.
// Depends on sst_pkg.
`default_nettype none
module sst_dpath
  import sst_pkg::*;
#(
  parameter int MAX_ENTRIES = 64,
  parameter int MAX_DIM     = 64,
  parameter int VALUE_BITS  = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  sst_cmd_t         cmd_i,
  input  wire logic [6:0]  row_i,
  input  wire logic [6:0]  col_i,
  input  wire logic [31:0] value_i,
  input  wire logic        present_i,
  input  wire logic [6:0]  col_count_i,
  input  wire logic        out_ready_i,
  output logic             out_valid_o,
  output logic             out_free_o,
  output logic [6:0]       out_row_o,
  output logic [6:0]       out_col_o,
  output logic [31:0]      out_value_o,
  output logic             out_last_o,
  output logic             out_err_o,
  output sst_status_t      status_o
);
  localparam int EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int DW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int NW = $clog2(MAX_ENTRIES + 1);
  localparam int RW = 14 + VALUE_BITS;

  // Per-entry steps of the count and scatter sweeps, and per-column steps of
  // the prefix sweep.
  localparam logic [1:0] STEP_READ  = 2'd0;
  localparam logic [1:0] STEP_FETCH = 2'd1;
  localparam logic [1:0] STEP_WRITE = 2'd2;

  logic [RW-1:0] estore [MAX_ENTRIES];
  logic [RW-1:0] tstore [MAX_ENTRIES];
  logic [NW-1:0] tally  [MAX_DIM];
  logic [NW-1:0] slot   [MAX_DIM];

  logic [NW-1:0] total_q;
  logic          drop_q;
  logic [NW-1:0] idx_q;
  logic [DW:0]   sweep_q;
  logic [1:0]    step_q;
  logic [NW-1:0] acc_q;
  logic [RW-1:0] erd_q;
  logic [NW-1:0] tal_q;
  logic [NW-1:0] srd_q;
  logic [RW-1:0] trd_q;
  logic          trd_v_q;
  logic [NW-1:0] trd_i_q;

  logic          ok;
  logic          walk;
  logic          t_issue;
  logic [DW-1:0] ecol;
  logic [DW-1:0] taddr;
  logic [VALUE_BITS-1:0] vfit;

  assign vfit = VALUE_BITS'(value_i);
  assign ok = present_i && (total_q < NW'(MAX_ENTRIES)) && (col_i != 7'd0) &&
              (col_i <= col_count_i) && (col_i <= 7'(MAX_DIM));
  assign ecol = DW'(erd_q[RW-8:RW-14] - 7'd1);
  assign walk = (idx_q < total_q);
  assign t_issue = cmd_i.emit && (!trd_v_q || cmd_i.emit_step) && walk;
  assign taddr = cmd_i.pref ? sweep_q[DW-1:0] : ecol;

  // Entry and transposed stores; every read is registered.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && ok) estore[total_q[EW-1:0]] <= {row_i, col_i, vfit};
    erd_q <= estore[idx_q[EW-1:0]];
    if (t_issue) trd_q <= tstore[idx_q[EW-1:0]];
    if (cmd_i.scat && step_q == STEP_WRITE)
      tstore[srd_q[EW-1:0]] <= {erd_q[RW-8:RW-14], erd_q[RW-1:RW-7],
                                erd_q[VALUE_BITS-1:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      drop_q  <= 1'b0;
    end else if (cmd_i.run_done) begin
      total_q <= '0;
      drop_q  <= 1'b0;
    end else if (cmd_i.load && present_i) begin
      if (ok) total_q <= total_q + NW'(1);
      else drop_q <= 1'b1;
    end
  end

  // Sweep control: each count or scatter entry steps through read, fetch and
  // write, so a tally or slot update is written before the next entry reads it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0; sweep_q <= '0; step_q <= STEP_READ; acc_q <= '0;
      trd_v_q <= 1'b0; trd_i_q <= '0;
    end else if (cmd_i.clear) begin
      idx_q <= '0; step_q <= STEP_READ; acc_q <= '0;
      sweep_q <= status_o.sweep_done ? '0 : sweep_q + 1'b1;
    end else if (cmd_i.count || cmd_i.scat) begin
      if (walk) begin
        case (step_q)
          STEP_READ:  step_q <= STEP_FETCH;
          STEP_FETCH: step_q <= STEP_WRITE;
          default: begin
            step_q <= STEP_READ;
            idx_q  <= idx_q + NW'(1);
          end
        endcase
      end else begin
        idx_q <= '0; step_q <= STEP_READ;
      end
    end else if (cmd_i.pref) begin
      if (step_q == STEP_READ) step_q <= STEP_FETCH;
      else begin
        step_q  <= STEP_READ;
        acc_q   <= acc_q + tal_q;
        sweep_q <= status_o.sweep_done ? '0 : sweep_q + 1'b1;
      end
    end else if (cmd_i.emit) begin
      // Prefetch transposed entries into a one-deep read register.
      if (t_issue) begin
        trd_v_q <= 1'b1; trd_i_q <= idx_q; idx_q <= idx_q + NW'(1);
      end else if (cmd_i.emit_step) trd_v_q <= 1'b0;
    end else begin
      idx_q <= '0; trd_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    tal_q <= tally[taddr];
    if (cmd_i.clear) tally[sweep_q[DW-1:0]] <= '0;
    else if (cmd_i.count && step_q == STEP_WRITE) tally[ecol] <= tal_q + NW'(1);
  end

  always_ff @(posedge clk_i) begin
    srd_q <= slot[ecol];
    if (cmd_i.pref && step_q == STEP_FETCH) slot[sweep_q[DW-1:0]] <= acc_q;
    else if (cmd_i.scat && step_q == STEP_WRITE) slot[ecol] <= srd_q + NW'(1);
  end

  assign status_o.total_zero = (total_q == '0);
  assign status_o.sweep_done = (sweep_q == (DW+1)'(MAX_DIM - 1)) &&
                               (cmd_i.clear || step_q == STEP_FETCH);
  assign status_o.item_done  = !walk;
  assign status_o.emit_last  = trd_v_q && (trd_i_q + NW'(1) == total_q);

  // Output register: loaded from the read register when empty or taken.
  assign out_free_o = trd_v_q && (!out_valid_o || out_ready_i);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (cmd_i.emit_step) out_valid_o <= 1'b1;
    else if (out_ready_i) out_valid_o <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_step) begin
      out_row_o   <= trd_q[RW-1:RW-7];
      out_col_o   <= trd_q[RW-8:RW-14];
      out_value_o <= 32'(signed'(trd_q[VALUE_BITS-1:0]));
      out_last_o  <= status_o.emit_last;
      out_err_o   <= drop_q;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> total_q <= NW'(MAX_ENTRIES)) else $error("entry count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_step |-> trd_v_q) else $error("emit without data");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.run_done |=> total_q == '0) else $error("count not cleared");
endmodule
`default_nettype wire

// ===== src/sparse_triple_transpose.sv =====
// Top level of the sparse triple transpose block.
// Depends on sst_pkg, sst_if, sst_ctrl and sst_dpath.
//
// Usage: triples arrive on in_ch, one transfer per cycle while loading. An
// entry is stored if present, the store has room and its column lies in
// 1..col_count and in 1..MAX_DIM; a present entry that fails is dropped and
// sets the error flag for the run. The transfer that carries last_entry closes
// the matrix. Input ready then drops while the block clears MAX_DIM column
// tallies, counts columns, forms start slots, scatters entries and streams
// the N transposed triples on out_ch, one per cycle while the receiver is
// ready. Stores are read through registers, hence the read, fetch and write
// steps per entry. A stalled receiver holds the output register and pauses
// the stream. An empty matrix gives no output and keeps ready low only through
// the clear and count states. Ready returns once the last triple sits in the
// output register. Reset empties the store and clears the flag; row_count and
// col_count reset to 64; the user must write them only while the block is
// idle, through cfg_we_i/cfg_idx_i/cfg_data_i; the block does not enforce it.
`default_nettype none
module sparse_triple_transpose
  import sst_pkg::*;
#(
  parameter int MAX_ENTRIES = 64,
  parameter int MAX_DIM     = 64,
  parameter int VALUE_BITS  = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_idx_i,
  input  wire logic [6:0] cfg_data_i,
  sst_if.sink             in_ch,
  sst_if.source           out_ch
);
  typedef struct packed {
    logic [6:0]  entry_row;
    logic [6:0]  entry_col;
    logic [31:0] entry_value;
    logic        entry_present;
    logic        last_entry;
  } in_t;
  typedef struct packed {
    logic [6:0]  out_row;
    logic [6:0]  out_col;
    logic [31:0] out_value;
    logic        out_last;
    logic        load_error;
  } out_t;

  in_t  in_d;
  out_t out_d;
  logic [6:0] row_count_q, col_count_q;
  logic in_ready, out_free;
  sst_cmd_t cmd;
  sst_status_t status;

  assign in_d = in_t'(in_ch.data);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= 7'd64;
      col_count_q <= 7'd64;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ROW_COUNT: row_count_q <= cfg_data_i;
        CFG_COL_COUNT: col_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sst_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_fire_i (in_ch.valid && in_ready),
    .in_last_i (in_d.last_entry),
    .out_free_i(out_free),
    .status_i  (status),
    .cmd_o     (cmd),
    .in_ready_o(in_ready)
  );

  sst_dpath #(.MAX_ENTRIES(MAX_ENTRIES), .MAX_DIM(MAX_DIM), .VALUE_BITS(VALUE_BITS)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i      (cmd),
    .row_i      (in_d.entry_row),
    .col_i      (in_d.entry_col),
    .value_i    (in_d.entry_value),
    .present_i  (in_d.entry_present),
    .col_count_i(col_count_q),
    .out_ready_i(out_ch.ready),
    .out_valid_o(out_ch.valid),
    .out_free_o (out_free),
    .out_row_o  (out_d.out_row),
    .out_col_o  (out_d.out_col),
    .out_value_o(out_d.out_value),
    .out_last_o (out_d.out_last),
    .out_err_o  (out_d.load_error),
    .status_o   (status)
  );

  assign in_ch.ready = in_ready;
  assign out_ch.data = out_d;
endmodule
`default_nettype wire

// ===== tb/sv/sst_transpose_checker.sv =====
// Checker for the sparse triple transpose block: watches both channels and
// the register port, predicts the transposed triples and compares them.
// Depends on sst_pkg.
`timescale 1ns / 100ps
module sst_transpose_checker
  import sst_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [6:0]  cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [47:0] in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [47:0] out_data_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          triples_seen_o,
  output int          dropped_runs_o
);

  typedef struct packed {
    logic [6:0]  row;
    logic [6:0]  col;
    logic [31:0] value;
    logic        last;
    logic        err;
  } triple_t;

  localparam int MaxEntries = 64;

  logic [6:0]  row_count_q, col_count_q;
  logic [6:0]  held_row [MaxEntries];
  logic [6:0]  held_col [MaxEntries];
  logic [31:0] held_val [MaxEntries];
  int          held_total;
  logic        dropped;
  triple_t     transposed_q [$];

  assign pending_o = transposed_q.size();

  // Loads one triple and, on the closing transfer, queues the transposed run.
  task automatic absorb_entry(input logic [47:0] d);
    logic [6:0]  r, c;
    logic [31:0] v;
    logic        present, last;
    int          k;
    triple_t     t;
    r = d[47:41]; c = d[40:34]; v = d[33:2]; present = d[1]; last = d[0];
    if (present) begin
      if (held_total >= MaxEntries || c == 0 || c > col_count_q || c > 7'd64) begin
        dropped = 1'b1;
      end else begin
        held_row[held_total] = r;
        held_col[held_total] = c;
        held_val[held_total] = v;
        held_total++;
      end
    end
    if (last) begin
      if (dropped) dropped_runs_o++;
      k = 0;
      // Walking columns in order and entries in load order gives the stable order.
      for (int col = 1; col <= 64; col++) begin
        for (int i = 0; i < held_total; i++) begin
          if (held_col[i] == col) begin
            k++;
            t.row = held_col[i];
            t.col = held_row[i];
            t.value = held_val[i];
            t.last = (k == held_total);
            t.err = dropped;
            transposed_q.push_back(t);
          end
        end
      end
      held_total = 0;
      dropped = 1'b0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    triple_t got, want;
    if (!rst_ni) begin
      row_count_q = 7'd64;
      col_count_q = 7'd64;
      held_total = 0;
      dropped = 1'b0;
      transposed_q.delete();
      fail_count_o = 0;
      triples_seen_o = 0;
      dropped_runs_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_ROW_COUNT) row_count_q = cfg_data_i;
        else col_count_q = cfg_data_i;
      end
      if (out_valid_i && out_ready_i) begin
        got = out_data_i;
        triples_seen_o++;
        if (transposed_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("%0t: unexpected transfer row=%0d col=%0d val=%h last=%b err=%b",
                     $realtime, got.row, got.col, got.value, got.last, got.err);
        end else begin
          want = transposed_q.pop_front();
          if (got != want) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("%0t: mismatch exp row=%0d col=%0d val=%h last=%b err=%b, got row=%0d col=%0d val=%h last=%b err=%b",
                       $realtime, want.row, want.col, want.value, want.last, want.err,
                       got.row, got.col, got.value, got.last, got.err);
          end
        end
      end
      if (in_valid_i && in_ready_i) absorb_entry(in_data_i);
    end
  end

endmodule

// ===== tb/sv/tb_sparse_triple_transpose.sv =====
// Top of the sparse triple transpose testbench: clock, reset, stimulus and
// verdict. Depends on sst_pkg, sst_if, the block and sst_transpose_checker.
`timescale 1ns / 100ps
module tb_sparse_triple_transpose;
  import sst_pkg::*;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic       cfg_idx_i = CFG_ROW_COUNT;
  logic [6:0] cfg_data_i = '0;
  int         fail_count, pending, triples_seen, dropped_runs;
  int         items_sent = 0;
  int         matrices_sent = 0;
  logic [6:0] col_limit = 7'd64;
  bit         steady_sink = 1'b0;

  sst_if #(.W(48)) in_ch ();
  sst_if #(.W(48)) out_ch ();

  always #5 clk_i = ~clk_i;

  sparse_triple_transpose DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_ch(in_ch), .out_ch(out_ch)
  );

  sst_transpose_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_valid_i(in_ch.valid), .in_ready_i(in_ch.ready),
    .in_data_i(in_ch.data), .out_valid_i(out_ch.valid), .out_ready_i(out_ch.ready),
    .out_data_i(out_ch.data), .fail_count_o(fail_count), .pending_o(pending),
    .triples_seen_o(triples_seen), .dropped_runs_o(dropped_runs)
  );

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  // Receiver: after each transfer it stalls at random, unless steady_sink is set.
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) stall = steady_sink ? 0 : $urandom_range(0, 6);
      @(negedge clk_i);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_triple(input logic [6:0] r, input logic [6:0] c,
                             input logic [31:0] v, input logic present,
                             input logic last);
    int gap;
    gap = steady_sink ? 0 : $urandom_range(0, 6);
    repeat (gap) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.data <= {r, c, v, present, last};
    in_ch.valid <= 1'b1;
    do @(posedge clk_i); while (!(in_ch.valid && in_ch.ready));
    @(negedge clk_i);
    items_sent++;
    if (last) matrices_sent++;
  endtask

  // Waits for every expected triple, then for the clearing sweeps that an
  // empty matrix still runs.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [6:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_COL_COUNT) col_limit = val;
  endtask

  // Random matrix of n items; most columns lie in range, a few are bad.
  task automatic send_matrix(input int n);
    logic [6:0] c;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) c = 7'($urandom_range(0, 127));
      else c = 7'($urandom_range(1, col_limit));
      send_triple(7'($urandom_range(0, 127)), c, $urandom(), $urandom_range(0, 9) != 0,
                  i == n - 1);
    end
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: extremes, dropped columns, markers, entry on the closing item.
    send_triple(7'd1, 7'd64, 32'h8000_0000, 1'b1, 1'b0);
    send_triple(7'd64, 7'd1, 32'h7FFF_FFFF, 1'b1, 1'b0);
    send_triple(7'd127, 7'd0, 32'hFFFF_FFFF, 1'b1, 1'b0);
    send_triple(7'd0, 7'd127, 32'h0, 1'b1, 1'b0);
    send_triple(7'd5, 7'd64, 32'h0000_0001, 1'b0, 1'b0);
    send_triple(7'd3, 7'd1, 32'h1234_5678, 1'b1, 1'b0);
    send_triple(7'd127, 7'd64, 32'hDEAD_BEEF, 1'b1, 1'b1);
    send_triple(7'd0, 7'd0, 32'h0, 1'b0, 1'b1);
    send_triple(7'd9, 7'd9, 32'h5555_AAAA, 1'b1, 1'b1);
    drain();
    write_reg(CFG_ROW_COUNT, 7'd1);
    write_reg(CFG_COL_COUNT, 7'd1);
    send_triple(7'd2, 7'd1, 32'hAAAA_5555, 1'b1, 1'b0);
    send_triple(7'd2, 7'd2, 32'h1, 1'b1, 1'b0);
    send_triple(7'd1, 7'd1, 32'h2, 1'b1, 1'b1);
    drain();
    write_reg(CFG_ROW_COUNT, 7'd64);
    write_reg(CFG_COL_COUNT, 7'd64);
    // Overfill the store so the capacity drop is hit.
    steady_sink = 1'b1;
    for (int i = 0; i < 66; i++)
      send_triple(7'($urandom_range(1, 64)), 7'($urandom_range(1, 64)), $urandom(), 1'b1,
                  i == 65);
    steady_sink = 1'b0;
    drain();

    // Random phases over several register settings.
    for (int phase = 0; phase < 4; phase++) begin
      write_reg(CFG_ROW_COUNT, 7'($urandom_range(1, 64)));
      write_reg(CFG_COL_COUNT,
                phase == 0 ? 7'd64 : phase == 1 ? 7'd1 : 7'($urandom_range(2, 63)));
      while (items_sent < 70 + 55 * (phase + 1)) begin
        steady_sink = $urandom_range(0, 4) == 0;
        send_matrix($urandom_range(0, 7) == 0 ? $urandom_range(30, 64) : $urandom_range(1, 10));
      end
      drain();
    end
    write_reg(CFG_ROW_COUNT, 7'd64);
    write_reg(CFG_COL_COUNT, 7'd64);
    send_matrix(12);
    drain();

    $display("Ran %0d items in %0d matrices, checked %0d transposed triples.",
             items_sent, matrices_sent, triples_seen);
    $display("%0d matrices dropped entries; settings included 1 and 64 columns.",
             dropped_runs);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

endmodule
